// File: rtl/bcc_pkg.sv
package bcc_pkg;

  localparam int COUNT_WIDTH_DEF = 16;
  localparam int CFG_W = 16;
  localparam int TICKS_W = 16;
  localparam int EV_W = 3;

  localparam logic [CFG_W-1:0] CLICK_WINDOW_RST = CFG_W'(25);
  localparam logic [CFG_W-1:0] LONG_LIMIT_RST = CFG_W'(200);

  typedef enum logic [EV_W-1:0] {
    EV_NONE        = 3'd0,
    EV_SINGLE      = 3'd1,
    EV_DOUBLE      = 3'd2,
    EV_LONG        = 3'd3,
    EV_PRESS_START = 3'd4
  } event_t;

  typedef enum logic {
    CFG_CLICK_WINDOW = 1'b0,
    CFG_LONG_LIMIT   = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic [CFG_W-1:0] click_window;
    logic [CFG_W-1:0] long_limit;
  } cfg_t;

endpackage

// File: rtl/bcc_cfg.sv
module bcc_cfg (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [bcc_pkg::CFG_W-1:0] cfg_data,
  output bcc_pkg::cfg_t             cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.click_window <= bcc_pkg::CLICK_WINDOW_RST;
      cfg.long_limit   <= bcc_pkg::LONG_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (bcc_pkg::cfg_index_t'(cfg_index))
        bcc_pkg::CFG_CLICK_WINDOW: cfg.click_window <= cfg_data;
        bcc_pkg::CFG_LONG_LIMIT:   cfg.long_limit   <= cfg_data;
      endcase
    end
  end

endmodule

// File: rtl/bcc_step.sv
module bcc_step #(
  parameter int COUNT_WIDTH = bcc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                        pressed,
  input  bcc_pkg::cfg_t               cfg,
  input  logic                        press_seen,
  input  logic                        press_counted,
  input  logic [1:0]                  click_tally,
  input  logic [COUNT_WIDTH-1:0]      window_ticks,
  input  logic [COUNT_WIDTH-1:0]      held_ticks,
  input  logic [COUNT_WIDTH-1:0]      long_run_ticks,
  input  logic                        long_fired,
  input  logic [COUNT_WIDTH-1:0]      press_total,
  output logic                        press_seen_next,
  output logic                        press_counted_next,
  output logic [1:0]                  click_tally_next,
  output logic [COUNT_WIDTH-1:0]      window_ticks_next,
  output logic [COUNT_WIDTH-1:0]      held_ticks_next,
  output logic [COUNT_WIDTH-1:0]      long_run_ticks_next,
  output logic                        long_fired_next,
  output logic [COUNT_WIDTH-1:0]      press_total_next,
  output bcc_pkg::event_t             event_code,
  output logic [bcc_pkg::TICKS_W-1:0] press_ticks
);

  localparam int CMPW = (COUNT_WIDTH > bcc_pkg::CFG_W) ? COUNT_WIDTH : bcc_pkg::CFG_W;
  localparam int PTW = (CMPW > bcc_pkg::TICKS_W) ? CMPW : bcc_pkg::TICKS_W;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    return (v == CNT_MAX) ? v : v + COUNT_WIDTH'(1);
  endfunction

  logic [CMPW-1:0] cw;
  logic [CMPW-1:0] ll;
  logic [PTW-1:0]  pt_ext;
  logic            click_done;

  assign cw = CMPW'(cfg.click_window);
  assign ll = CMPW'(cfg.long_limit);

  always_comb begin
    press_seen_next     = press_seen | pressed;
    press_counted_next  = press_counted;
    click_tally_next    = click_tally;
    window_ticks_next   = window_ticks;
    held_ticks_next     = pressed ? sat_inc(held_ticks) : '0;
    long_run_ticks_next = long_run_ticks;
    long_fired_next     = long_fired;
    press_total_next    = press_total;
    event_code          = bcc_pkg::EV_NONE;
    click_done          = 1'b0;

    // click stage
    if (!press_counted) begin
      if (press_seen_next) begin
        if (click_tally != 2'd3) click_tally_next = click_tally + 2'd1;
        press_counted_next = 1'b1;
      end
      if (click_tally_next == 2'd2) begin
        click_tally_next  = 2'd0;
        window_ticks_next = '0;
        event_code        = bcc_pkg::EV_DOUBLE;
        click_done        = 1'b1;
      end
    end
    if (!click_done) begin
      if (!pressed) begin
        press_seen_next    = 1'b0;
        press_counted_next = 1'b0;
      end
      if (click_tally_next == 2'd1) begin
        window_ticks_next = sat_inc(window_ticks);
        if (CMPW'(window_ticks_next) > cw && CMPW'(held_ticks_next) < cw) begin
          click_tally_next  = 2'd0;
          window_ticks_next = '0;
          event_code        = bcc_pkg::EV_SINGLE;
          click_done        = 1'b1;
        end else if (CMPW'(held_ticks_next) > cw) begin
          click_tally_next  = 2'd0;
          window_ticks_next = '0;
        end
      end
    end

    // long-press stage, only when no click was reported
    if (!click_done) begin
      if (!long_fired && pressed) begin
        press_total_next    = sat_inc(press_total);
        long_run_ticks_next = sat_inc(long_run_ticks);
      end else begin
        long_run_ticks_next = '0;
      end
      if (CMPW'(long_run_ticks_next) > ll) begin
        long_fired_next     = 1'b1;
        long_run_ticks_next = '0;
        event_code          = bcc_pkg::EV_LONG;
      end else if (long_run_ticks_next == COUNT_WIDTH'(1)) begin
        press_total_next = '0;
        event_code       = bcc_pkg::EV_PRESS_START;
      end else begin
        long_fired_next = 1'b0;
      end
    end
  end

  assign pt_ext      = PTW'(press_total_next);
  assign press_ticks = pt_ext[bcc_pkg::TICKS_W-1:0];

endmodule

// File: rtl/button_click_classifier_core.sv
// channel | direction | handshake           | payload
// --------+-----------+---------------------+------------------------
// in      | input     | in_valid / in_ready | key_level
// out     | output    | out_valid/out_ready | event_code, press_ticks
// cfg     | input     | cfg_we (no wait)    | cfg_index, cfg_data
//
// One item per cycle while the output is not stalled: the tick is classified in one pass from the state
// registers and lands in the result register on the accepting edge.
// The result is registered; in_ready is low while the result register is full
// and out_ready is low, so a stall costs no item.
// Synchronous reset clears all state and the result valid; config returns
// to click_window 25, long_limit 200.
module button_click_classifier_core #(
  parameter int COUNT_WIDTH = bcc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        key_level,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [bcc_pkg::EV_W-1:0]    event_code,
  output logic [bcc_pkg::TICKS_W-1:0] press_ticks,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [bcc_pkg::CFG_W-1:0]   cfg_data
);

  bcc_pkg::cfg_t cfg;

  logic                   press_seen, press_seen_next;
  logic                   press_counted, press_counted_next;
  logic [1:0]             click_tally, click_tally_next;
  logic [COUNT_WIDTH-1:0] window_ticks, window_ticks_next;
  logic [COUNT_WIDTH-1:0] held_ticks, held_ticks_next;
  logic [COUNT_WIDTH-1:0] long_run_ticks, long_run_ticks_next;
  logic                   long_fired, long_fired_next;
  logic [COUNT_WIDTH-1:0] press_total, press_total_next;

  bcc_pkg::event_t             ev_next;
  logic [bcc_pkg::TICKS_W-1:0] ticks_next;
  logic                        accept;

  bcc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bcc_step #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_step (
    .pressed             (~key_level),
    .cfg                 (cfg),
    .press_seen          (press_seen),
    .press_counted       (press_counted),
    .click_tally         (click_tally),
    .window_ticks        (window_ticks),
    .held_ticks          (held_ticks),
    .long_run_ticks      (long_run_ticks),
    .long_fired          (long_fired),
    .press_total         (press_total),
    .press_seen_next     (press_seen_next),
    .press_counted_next  (press_counted_next),
    .click_tally_next    (click_tally_next),
    .window_ticks_next   (window_ticks_next),
    .held_ticks_next     (held_ticks_next),
    .long_run_ticks_next (long_run_ticks_next),
    .long_fired_next     (long_fired_next),
    .press_total_next    (press_total_next),
    .event_code          (ev_next),
    .press_ticks         (ticks_next)
  );

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      press_seen     <= 1'b0;
      press_counted  <= 1'b0;
      click_tally    <= 2'd0;
      window_ticks   <= '0;
      held_ticks     <= '0;
      long_run_ticks <= '0;
      long_fired     <= 1'b0;
      press_total    <= '0;
      out_valid      <= 1'b0;
    end else if (accept) begin
      press_seen     <= press_seen_next;
      press_counted  <= press_counted_next;
      click_tally    <= click_tally_next;
      window_ticks   <= window_ticks_next;
      held_ticks     <= held_ticks_next;
      long_run_ticks <= long_run_ticks_next;
      long_fired     <= long_fired_next;
      press_total    <= press_total_next;
      out_valid      <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // result payload, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      event_code  <= ev_next;
      press_ticks <= ticks_next;
    end
  end

endmodule
